@@ src/configurable_fibonacci_lfsr_core_defines.svh @@
// Assertion macros for the top level of the LFSR core.
`ifndef CONFIGURABLE_FIBONACCI_LFSR_CORE_DEFINES_SVH
`define CONFIGURABLE_FIBONACCI_LFSR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");
`define CFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define CFL_ASSERT_ALWAYS(label, clk, rst, cond)
`define CFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/cfl_pkg.sv @@
// Shared types, codes and tap table for the Fibonacci LFSR core.
package cfl_pkg;

   localparam int CFL_MAX_WIDTH = 16;
   localparam int CFL_MIN_WIDTH = 3;

   localparam logic [2:0] KIND_BIT    = 3'd0;
   localparam logic [2:0] KIND_BYTE   = 3'd1;
   localparam logic [2:0] KIND_WORD   = 3'd2;
   localparam logic [2:0] KIND_RESEED = 3'd3;
   localparam logic [2:0] KIND_SET    = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] load_value;
   } req_type;

   typedef struct packed {
      logic [15:0] random_bits;
      logic [15:0] shift_state;
      logic [31:0] step_count;
      logic        load_error;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       start;
      logic       step;
      logic [3:0] step_idx;
      logic       finish;
   } cmd_type;

   function automatic logic [15:0] tap_mask(input logic [4:0] width);
      logic [15:0] taps;
      case (width)
         5'd3:    taps = 16'h0003;
         5'd4:    taps = 16'h0009;
         5'd5:    taps = 16'h0012;
         5'd6:    taps = 16'h0021;
         5'd7:    taps = 16'h0041;
         5'd8:    taps = 16'h008E;
         5'd9:    taps = 16'h0108;
         5'd10:   taps = 16'h0204;
         5'd11:   taps = 16'h0402;
         5'd12:   taps = 16'h0829;
         5'd13:   taps = 16'h100D;
         5'd14:   taps = 16'h2015;
         5'd15:   taps = 16'h4001;
         5'd16:   taps = 16'h8016;
         default: taps = 16'h0003;
      endcase
      return taps;
   endfunction

   function automatic logic [15:0] width_mask(input logic [4:0] width);
      logic [16:0] full;
      full = (17'd1 << width) - 17'd1;
      return full[15:0];
   endfunction

   function automatic logic [4:0] clamp_width(input logic [4:0] w, input logic [4:0] top);
      logic [4:0] res;
      if (w < 5'(CFL_MIN_WIDTH)) begin
         res = 5'(CFL_MIN_WIDTH);
      end else if (w > top) begin
         res = top;
      end else begin
         res = w;
      end
      return res;
   endfunction

endpackage

@@ src/cfl_ctrl.sv @@
// Sequencer: accepts a word, runs the step loop for bit, byte and word kinds, hands the result to the output slot.
module cfl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_kind,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfl_pkg::cmd_type cmd
);
   import cfl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.start    = accept;
      cmd.step     = (state_ff == ST_RUN);
      cmd.step_idx = idx_ff;
      cmd.finish   = (state_ff == ST_WAIT) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = 4'd0;
               case (req_kind)
                  KIND_BIT: begin
                     last_in  = 4'd0;
                     state_in = ST_RUN;
                  end
                  KIND_BYTE: begin
                     last_in  = 4'd7;
                     state_in = ST_RUN;
                  end
                  KIND_WORD: begin
                     last_in  = 4'd15;
                     state_in = ST_RUN;
                  end
                  default: state_in = ST_WAIT;
               endcase
            end
         end
         ST_RUN: begin
            if (idx_ff == last_ff) begin
               state_in = ST_WAIT;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ST_WAIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 4'd0;
         last_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/cfl_datapath.sv @@
// Shift register, step counter, width register and result register.
module cfl_datapath #(
   parameter int MAX_WIDTH = cfl_pkg::CFL_MAX_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  cfl_pkg::cmd_type cmd,
   input  cfl_pkg::req_type req_word,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data,
   output cfl_pkg::rsp_type rsp_word
);
   import cfl_pkg::*;

   localparam logic [4:0] TopWidth = 5'(MAX_WIDTH);

   logic [4:0]  width_ff, width_in;
   logic [15:0] shift_ff, shift_in;
   logic [31:0] count_ff, count_in;
   logic [15:0] bits_ff, bits_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] load_ff, load_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] mask;
   logic        fb;
   logic [15:0] load_m;
   logic [4:0]  new_width;
   logic [15:0] new_mask;
   logic [15:0] cfg_shift;

   assign mask   = width_mask(width_ff);
   assign fb     = ^(shift_ff & tap_mask(width_ff));
   assign load_m = load_ff & mask;

   assign new_width = clamp_width(csr_wr_data, TopWidth);
   assign new_mask  = width_mask(new_width);
   assign cfg_shift = shift_ff & new_mask;

   always_comb begin
      width_in = width_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      bits_in  = bits_ff;
      kind_in  = kind_ff;
      load_in  = load_ff;
      rsp_in   = rsp_ff;

      if (csr_wr_en) begin
         width_in = new_width;
         shift_in = (cfg_shift == 16'd0) ? 16'd1 : cfg_shift;
      end

      if (cmd.start) begin
         kind_in = req_word.kind;
         load_in = req_word.load_value;
         bits_in = 16'd0;
      end

      if (cmd.step) begin
         shift_in = ((shift_ff >> 1) | (16'(fb) << (width_ff - 5'd1))) & mask;
         count_in = count_ff + 32'd1;
         bits_in  = bits_ff | (16'(fb) << cmd.step_idx);
      end

      if (cmd.finish) begin
         rsp_in.load_error = 1'b0;
         rsp_in.random_bits = bits_ff;
         case (kind_ff)
            KIND_BIT, KIND_BYTE, KIND_WORD: ;
            KIND_RESEED: begin
               shift_in           = (load_m == 16'd0) ? 16'd1 : load_m;
               count_in           = 32'd0;
               rsp_in.random_bits = shift_in;
            end
            KIND_SET: begin
               if (load_m == 16'd0) begin
                  rsp_in.load_error = 1'b1;
               end else begin
                  shift_in = load_m;
                  count_in = 32'd0;
               end
               rsp_in.random_bits = shift_in;
            end
            default: rsp_in.random_bits = 16'd0;
         endcase
         rsp_in.shift_state = shift_in;
         rsp_in.step_count  = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= TopWidth;
         shift_ff <= 16'd1;
         count_ff <= 32'd0;
      end else begin
         width_ff <= width_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
      bits_ff <= bits_in;
      kind_ff <= kind_in;
      load_ff <= load_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule

@@ src/configurable_fibonacci_lfsr_core.sv @@
// Top level of the configurable-width Fibonacci LFSR core.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_word (kind, load_value)
//   rsp      out        rsp_valid/rsp_stall  rsp_word (bits, state, count, error)
//   csr      in         csr_wr_en            csr_wr_data (width_bits)
//
// One LFSR step per cycle in the shift datapath: a word runs n = 1, 8 or 16 steps
// between its acceptance and the next acceptance; loads run no steps.
// The result register frees the input side: a new word is taken while the last
// result still waits; rsp_stall only holds the finish of the following word.
// Synchronous reset: width = MAX_WIDTH, state = 1, step count = 0, no result.
`include "configurable_fibonacci_lfsr_core_defines.svh"
module configurable_fibonacci_lfsr_core #(
   parameter int MAX_WIDTH = cfl_pkg::CFL_MAX_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfl_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfl_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);
   import cfl_pkg::*;

   cmd_type cmd;

   cfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_word.kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cfl_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_word    (rsp_word)
   );

   // an accepted word keeps the input side busy in the following cycle
   `CFL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a finish never overwrites a result that is still being stalled
   `CFL_ASSERT_ALWAYS(a_no_overwrite, clock, reset, !(cmd.finish && rsp_valid && rsp_stall))
   // steps only run while a word is in flight
   `CFL_ASSERT_ALWAYS(a_step_in_flight, clock, reset, !(cmd.step && !req_stall))
   // a finish is followed by a valid result
   `CFL_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the configurable Fibonacci LFSR core.
`timescale 1ns / 1ps

module tb_top;
   import cfl_pkg::*;

   // one tap polynomial per width, width 3 in the low slice
   localparam logic [14*16-1:0] POLY_TAPS = {
      16'h8016, 16'h4001, 16'h2015, 16'h100D, 16'h0829, 16'h0402, 16'h0204,
      16'h0108, 16'h008E, 16'h0041, 16'h0021, 16'h0012, 16'h0009, 16'h0003
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;
   logic    csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = '0;

   // predictor state
   logic [4:0]  model_width;
   logic [15:0] model_reg;
   logic [31:0] model_steps;

   rsp_type lfsr_words_due[$];
   int      mismatch_count = 0;
   int      rsp_hold = 0;
   bit      calm = 1'b0;

   configurable_fibonacci_lfsr_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int idle_cycles();
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [15:0] active_mask(input logic [4:0] w);
      return 16'((32'd1 << w) - 32'd1);
   endfunction

   function automatic logic [4:0] limit_width(input logic [4:0] v);
      if (v < 5'(CFL_MIN_WIDTH)) return 5'(CFL_MIN_WIDTH);
      if (v > 5'(CFL_MAX_WIDTH)) return 5'(CFL_MAX_WIDTH);
      return v;
   endfunction

   // advances the predictor by one request and returns the word it should produce
   function automatic rsp_type next_lfsr_word(input req_type item);
      rsp_type     r;
      logic [15:0] msk;
      logic [15:0] load;
      logic [15:0] bits;
      logic [15:0] taps;
      logic        fb;
      int          n;
      msk  = active_mask(model_width);
      load = item.load_value & msk;
      taps = POLY_TAPS[(int'(model_width) - 3) * 16 +: 16];
      bits = '0;
      case (item.kind)
         KIND_BIT:  n = 1;
         KIND_BYTE: n = 8;
         KIND_WORD: n = 16;
         default:   n = 0;
      endcase
      for (int i = 0; i < n; i++) begin
         fb = ^(model_reg & taps);
         model_reg = ((model_reg >> 1) | (16'(fb) << (model_width - 5'd1))) & msk;
         model_steps = model_steps + 32'd1;
         bits[i] = fb;
      end
      r.load_error = 1'b0;
      if (item.kind == KIND_RESEED) begin
         model_reg   = (load == '0) ? 16'h0001 : load;
         model_steps = '0;
         bits        = model_reg;
      end else if (item.kind == KIND_SET) begin
         if (load == '0) begin
            r.load_error = 1'b1;
         end else begin
            model_reg   = load;
            model_steps = '0;
         end
         bits = model_reg;
      end
      r.random_bits = bits;
      r.shift_state = model_reg;
      r.step_count  = model_steps;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
   endtask

   task automatic issue_request(input logic [2:0] kind, input logic [15:0] load_value);
      req_type item;
      int      gap;
      item.kind       = kind;
      item.load_value = load_value;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= item;
      do @(posedge clock); while (req_stall);
      lfsr_words_due = {lfsr_words_due, next_lfsr_word(item)};
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (lfsr_words_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_width(input logic [4:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_width = limit_width(value);
      model_reg   = model_reg & active_mask(model_width);
      if (model_reg == '0) model_reg = 16'h0001;
   endtask

   // receiver: after each word taken, draws a random hold and stalls until it runs out (a zero draw means no stall)
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         rsp_hold = idle_cycles();
         rsp_stall <= (rsp_hold != 0);
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_stall <= (rsp_hold != 0);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lfsr_words_due.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_word.random_bits), '0);
         end else begin
            want = lfsr_words_due.pop_front();
            if (rsp_word.random_bits !== want.random_bits)
               report_mismatch("random_bits", 32'(rsp_word.random_bits),
                               32'(want.random_bits));
            if (rsp_word.shift_state !== want.shift_state)
               report_mismatch("shift_state", 32'(rsp_word.shift_state),
                               32'(want.shift_state));
            if (rsp_word.step_count !== want.step_count)
               report_mismatch("step_count", rsp_word.step_count, want.step_count);
            if (rsp_word.load_error !== want.load_error)
               report_mismatch("load_error", 32'(rsp_word.load_error),
                               32'(want.load_error));
         end
      end
   end

   task automatic test_after_reset();
      issue_request(KIND_BIT, 16'h0000);
      issue_request(KIND_BYTE, 16'hFFFF);
      issue_request(KIND_WORD, 16'h0000);
      // unused kinds leave everything alone
      issue_request(3'd5, 16'hFFFF);
      issue_request(3'd6, 16'h1234);
      issue_request(3'd7, 16'h0000);
   endtask

   task automatic test_loads();
      write_width(5'd8);
      issue_request(KIND_RESEED, 16'h0000);   // zero seed becomes 1
      issue_request(KIND_RESEED, 16'hFF00);   // zero once masked
      issue_request(KIND_SET, 16'h0000);      // refused
      issue_request(KIND_SET, 16'h0F00);      // refused, no bits inside width
      issue_request(KIND_SET, 16'h00FF);
      issue_request(KIND_WORD, 16'h0000);
      write_width(5'd16);
      issue_request(KIND_SET, 16'hFFFF);
      issue_request(KIND_RESEED, 16'hFFFF);
   endtask

   task automatic test_width_changes();
      issue_request(KIND_SET, 16'h8000);
      write_width(5'd3);                      // masks state to zero, forced to 1
      issue_request(KIND_WORD, 16'h0000);
      write_width(5'd0);
      issue_request(KIND_BYTE, 16'h0000);
      write_width(5'd31);
      issue_request(KIND_WORD, 16'h0000);
      write_width(5'd17);
      issue_request(KIND_BIT, 16'h0000);
      write_width(5'd2);
      issue_request(KIND_BIT, 16'h0000);
      write_width(5'd9);
      issue_request(KIND_RESEED, 16'h01FF);
      issue_request(KIND_WORD, 16'h0000);
   endtask

   task automatic test_random_traffic();
      logic [4:0]  w;
      logic [15:0] load;
      logic [2:0]  kind;
      int          pick;
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 5))
            0:       w = 5'd3;
            1:       w = 5'd16;
            2:       w = 5'($urandom_range(0, 31));
            default: w = 5'($urandom_range(3, 16));
         endcase
         write_width(w);
         calm = (phase % 3 == 2);
         for (int i = 0; i < 60; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      kind = KIND_BIT;
            else if (pick < 55) kind = KIND_BYTE;
            else if (pick < 75) kind = KIND_WORD;
            else if (pick < 85) kind = KIND_RESEED;
            else if (pick < 95) kind = KIND_SET;
            else                kind = 3'($urandom_range(5, 7));
            case ($urandom_range(0, 9))
               0:       load = '0;
               1:       load = 16'($urandom_range(0, 65535)) & ~active_mask(model_width);
               default: load = 16'($urandom_range(0, 65535));
            endcase
            issue_request(kind, load);
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      model_width = 5'(CFL_MAX_WIDTH);
      model_reg   = 16'h0001;
      model_steps = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_loads();
      test_width_changes();
      test_random_traffic();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/cfl_pkg.sv
src/cfl_ctrl.sv
src/cfl_datapath.sv
src/configurable_fibonacci_lfsr_core.sv
verif/tb_top.sv
